@@ hw/rtl/optical_depth_trapezoid_accumulator_defines.svh @@
// Assertion macros for the optical depth accumulator checker
`ifndef OPTICAL_DEPTH_TRAPEZOID_ACCUMULATOR_DEFINES_SVH
`define OPTICAL_DEPTH_TRAPEZOID_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while rstn is low
`define ODTA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rstn is low
`define ODTA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/odta_pkg.sv @@
// Shared types and constants of the optical depth trapezoid accumulator
`default_nettype none

package odta_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int DEPTH_W        = 48;
    localparam int INDEX_W        = 8;
    localparam int STOP_W         = 9;
    localparam int TOP_W          = 9;
    localparam int BOTTOM_W       = 8;
    localparam int COUNT_W        = 9;
    localparam int PROD_W         = 2 * SAMPLE_W;
    localparam int FRAC_W         = 16;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 5;
    localparam int MAX_LAYERS_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_MAX_DEPTH    = 2'd0;
    localparam logic [1:0] REG_TOP_LAYER    = 2'd1;
    localparam logic [1:0] REG_BOTTOM_LAYER = 2'd2;
    localparam logic [1:0] REG_LAYER_COUNT  = 2'd3;

    // Layer-selection configuration seen by the front end
    typedef struct packed {
        logic [TOP_W-1:0]    top_layer;
        logic [BOTTOM_W-1:0] bottom_layer;
        logic [COUNT_W-1:0]  layer_count;
    } layer_cfg_t;

    // Classification of one layer, decided at accept time
    typedef struct packed {
        logic [INDEX_W-1:0] layer_index;
        logic [STOP_W-1:0]  stop_index;
        logic               above_top;
        logic               stop_early;   // stop regardless of depth
        logic               last_layer;
    } layer_meta_t;

    // One queued layer: halved sample sum, gated spacing and its class
    typedef struct packed {
        logic [SAMPLE_W-1:0] sum_half;
        logic                sum_odd;
        logic [SAMPLE_W-1:0] spacing;
        layer_meta_t         meta;
    } queue_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/odta_front.sv @@
// Front end: accepts layers, tracks the layer counter and classifies each layer
`default_nettype none

module odta_front #(
    parameter int MAX_LAYERS = odta_pkg::MAX_LAYERS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [odta_pkg::SAMPLE_W-1:0]   s_extinction_sample,
    input  wire logic [odta_pkg::SAMPLE_W-1:0]   s_layer_spacing,
    input  wire odta_pkg::layer_cfg_t            cfg,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output odta_pkg::queue_entry_t               q_entry
);
    import odta_pkg::*;

    localparam int CW = $clog2(MAX_LAYERS);
    localparam int NW = $clog2(MAX_LAYERS + 1);
    localparam int XW = ((NW > COUNT_W) ? NW : COUNT_W) + 1;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_LAYERS);

    logic [CW-1:0]       layer_reg, layer_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;

    logic [XW-1:0]       k_x, cnt_x, nl_x;
    logic                last, above_top, bottom_hit, add_en;
    logic [SAMPLE_W:0]   sum;

    // Effective layer count: zero acts as one, clipped to the array size
    always_comb begin
        k_x   = XW'(layer_reg);
        cnt_x = XW'(cfg.layer_count);
        priority if (cnt_x == '0) begin
            nl_x = XW'(1);
        end else if (cnt_x > MAX_X) begin
            nl_x = MAX_X;
        end else begin
            nl_x = cnt_x;
        end
    end

    // Layer classification
    assign last       = (k_x >= (nl_x - XW'(1)));
    assign above_top  = !cfg.top_layer[TOP_W-1] && (k_x <= XW'(cfg.top_layer));
    assign bottom_hit = (k_x == XW'(cfg.bottom_layer));
    assign add_en     = !above_top && (layer_reg != '0);

    // Trapezoid sum; the sum is split into sum/2 and its odd bit
    assign sum = {1'b0, s_extinction_sample} + {1'b0, prev_reg};

    always_comb begin
        q_entry.sum_half         = sum[SAMPLE_W:1];
        q_entry.sum_odd          = sum[0];
        q_entry.spacing          = add_en ? s_layer_spacing : '0;
        q_entry.meta.layer_index = k_x[INDEX_W-1:0];
        q_entry.meta.stop_index  = above_top ? nl_x[STOP_W-1:0] : k_x[STOP_W-1:0];
        q_entry.meta.above_top   = above_top;
        q_entry.meta.stop_early  = above_top ? last : (bottom_hit || last);
        q_entry.meta.last_layer  = last;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Counter and previous sample; both clear after the column's last layer
    always_comb begin
        layer_next = layer_reg;
        prev_next  = prev_reg;
        if (q_push) begin
            if (last) begin
                layer_next = '0;
                prev_next  = '0;
            end else begin
                layer_next = layer_reg + CW'(1);
                prev_next  = s_extinction_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_reg <= '0;
            prev_reg  <= '0;
        end else begin
            layer_reg <= layer_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/odta_queue.sv @@
// Short FIFO of classified layers between front and back end
`default_nettype none

module odta_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire odta_pkg::queue_entry_t push_entry,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        head_valid,
    output odta_pkg::queue_entry_t      head_entry
);
    import odta_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    queue_entry_t   slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full       = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Pointer wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (QAW+1)'(1);
            2'b01:   count_next = count_reg - (QAW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/odta_back.sv @@
// Back end: trapezoid multiply, saturating accumulation, stop logic, output register
`default_nettype none

module odta_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire odta_pkg::queue_entry_t        q_entry,
    output logic                               q_pop,
    input  wire logic [odta_pkg::DEPTH_W-1:0]  max_depth,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [odta_pkg::DEPTH_W-1:0]       m_depth_value,
    output logic [odta_pkg::INDEX_W-1:0]       m_layer_index,
    output logic                               m_column_stop,
    output logic [odta_pkg::STOP_W-1:0]        m_stop_layer
);
    import odta_pkg::*;

    // Multiply stage
    logic                mv_reg, mv_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    layer_meta_t         meta_reg;

    // Column state
    logic [DEPTH_W-1:0]  run_reg, run_next;
    logic                stopped_reg, stopped_next;

    // Output register
    logic                ov_reg, ov_next;
    logic [DEPTH_W-1:0]  odepth_reg;
    logic [INDEX_W-1:0]  oindex_reg;
    logic                ostop_reg;
    logic [STOP_W-1:0]   ostopl_reg;

    logic [DEPTH_W:0]    acc_sum;
    logic [DEPTH_W-1:0]  depth_new;
    logic                emit, stop, retire, load_m;

    // spacing * (a + b) / 2 as spacing * floor(sum/2) plus half the spacing when odd
    assign prod_next = PROD_W'(q_entry.spacing) * PROD_W'(q_entry.sum_half)
                     + PROD_W'(q_entry.sum_odd ? (q_entry.spacing >> 1) : '0);

    // Saturating accumulate of the Q32.16 increment
    assign acc_sum   = {1'b0, run_reg} + {1'b0, prod_reg[PROD_W-1:FRAC_W]};
    assign depth_new = acc_sum[DEPTH_W] ? {DEPTH_W{1'b1}} : acc_sum[DEPTH_W-1:0];

    assign emit = !stopped_reg;
    assign stop = meta_reg.above_top ? meta_reg.stop_early
                                     : (meta_reg.stop_early || (depth_new >= max_depth));

    // A layer retires once its result has a place, or at once if it gives none
    assign retire = mv_reg && (!emit || !ov_reg || m_ready);
    assign load_m = q_valid && (!mv_reg || retire);
    assign q_pop  = load_m;

    always_comb begin
        mv_next = mv_reg;
        if (load_m) begin
            mv_next = 1'b1;
        end else if (retire) begin
            mv_next = 1'b0;
        end
    end

    // Column state update at retire
    always_comb begin
        run_next     = run_reg;
        stopped_next = stopped_reg;
        if (retire) begin
            if (meta_reg.last_layer) begin
                run_next     = '0;
                stopped_next = 1'b0;
            end else if (emit) begin
                run_next     = depth_new;
                stopped_next = stop;
            end
        end
    end

    always_comb begin
        ov_next = ov_reg;
        if (retire && emit) begin
            ov_next = 1'b1;
        end else if (m_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg      <= 1'b0;
            run_reg     <= '0;
            stopped_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            mv_reg      <= mv_next;
            run_reg     <= run_next;
            stopped_reg <= stopped_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load_m) begin
            prod_reg <= prod_next;
            meta_reg <= q_entry.meta;
        end
        if (retire && emit) begin
            odepth_reg <= meta_reg.above_top ? '0 : depth_new;
            oindex_reg <= meta_reg.layer_index;
            ostop_reg  <= stop;
            ostopl_reg <= stop ? meta_reg.stop_index : '0;
        end
    end

    assign m_valid       = ov_reg;
    assign m_depth_value = odepth_reg;
    assign m_layer_index = oindex_reg;
    assign m_column_stop = ostop_reg;
    assign m_stop_layer  = ostopl_reg;

endmodule

`default_nettype wire

@@ hw/rtl/optical_depth_trapezoid_accumulator.sv @@
// Optical depth trapezoid accumulator: top level with the APB register file
//
// Takes one layer per transaction (extinction Q16.16, spacing Q16.16) and gives
// one Q32.16 optical depth per layer until the column stops, using the cumulative
// trapezoidal rule with saturation at full scale. Sustained rate is one layer per
// clock cycle while m_ready is high: the only loop is the add, saturate and compare
// on the running depth in the back end. A layer's result passes the queue slot, the
// multiply register and the output register in that order before it shows on
// m_valid; the 32x32 multiply sits in its own stage. A four-entry queue parts the
// front end from the back end, so input transactions keep flowing while a result
// waits on m_ready, until the queue fills.
// Registers (64-bit APB, byte address 8*index): max_depth, top_layer, bottom_layer,
// layer_count; write them only while the block is idle. No clearing pass after reset.
`default_nettype none

module optical_depth_trapezoid_accumulator #(
    parameter int MAX_LAYERS = odta_pkg::MAX_LAYERS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [odta_pkg::SAMPLE_W-1:0]     s_extinction_sample,
    input  wire logic [odta_pkg::SAMPLE_W-1:0]     s_layer_spacing,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [odta_pkg::DEPTH_W-1:0]           m_depth_value,
    output logic [odta_pkg::INDEX_W-1:0]           m_layer_index,
    output logic                                   m_column_stop,
    output logic [odta_pkg::STOP_W-1:0]            m_stop_layer,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [odta_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [odta_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [odta_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import odta_pkg::*;

    logic [DEPTH_W-1:0]  max_depth_reg;
    logic [TOP_W-1:0]    top_layer_reg;
    logic [BOTTOM_W-1:0] bottom_layer_reg;
    logic [COUNT_W-1:0]  layer_count_reg;

    logic [1:0]          reg_sel;
    logic                wr_en;
    layer_cfg_t          layer_cfg;

    logic                q_push, q_full, q_pop, q_valid;
    queue_entry_t        q_in, q_head;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg    <= {DEPTH_W{1'b1}};
            top_layer_reg    <= {TOP_W{1'b1}};
            bottom_layer_reg <= {BOTTOM_W{1'b1}};
            layer_count_reg  <= COUNT_W'(MAX_LAYERS_DEF);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MAX_DEPTH:    max_depth_reg    <= pwdata[DEPTH_W-1:0];
                REG_TOP_LAYER:    top_layer_reg    <= pwdata[TOP_W-1:0];
                REG_BOTTOM_LAYER: bottom_layer_reg <= pwdata[BOTTOM_W-1:0];
                REG_LAYER_COUNT:  layer_count_reg  <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    // Read-back; top_layer is returned sign-extended
    always_comb begin
        unique case (reg_sel)
            REG_MAX_DEPTH:    prdata = APB_DATA_W'(max_depth_reg);
            REG_TOP_LAYER:    prdata = {{(APB_DATA_W-TOP_W){top_layer_reg[TOP_W-1]}},
                                        top_layer_reg};
            REG_BOTTOM_LAYER: prdata = APB_DATA_W'(bottom_layer_reg);
            REG_LAYER_COUNT:  prdata = APB_DATA_W'(layer_count_reg);
        endcase
    end

    assign layer_cfg.top_layer    = top_layer_reg;
    assign layer_cfg.bottom_layer = bottom_layer_reg;
    assign layer_cfg.layer_count  = layer_count_reg;

    odta_front #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_extinction_sample (s_extinction_sample),
        .s_layer_spacing     (s_layer_spacing),
        .cfg                 (layer_cfg),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_entry             (q_in)
    );

    odta_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    odta_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_head),
        .q_pop         (q_pop),
        .max_depth     (max_depth_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_depth_value (m_depth_value),
        .m_layer_index (m_layer_index),
        .m_column_stop (m_column_stop),
        .m_stop_layer  (m_stop_layer)
    );

endmodule

`default_nettype wire

@@ hw/rtl/odta_checker.sv @@
// Port-level checker for the optical depth accumulator, bound to the top level
`default_nettype none

`include "optical_depth_trapezoid_accumulator_defines.svh"

module odta_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [odta_pkg::DEPTH_W-1:0]  m_depth_value,
    input wire logic [odta_pkg::INDEX_W-1:0]  m_layer_index,
    input wire logic                          m_column_stop,
    input wire logic [odta_pkg::STOP_W-1:0]   m_stop_layer
);

    // A stalled result stays put
    `ODTA_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_depth_value) && $stable(m_layer_index) && $stable(m_column_stop) && $stable(m_stop_layer), "result changed while stalled")

    // No result straight after reset
    `ODTA_ASSERT_NEXT(a_reset_quiet, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

    // Stop index only accompanies a column stop
    `ODTA_ASSERT_IMPLIES(a_stop_layer_zero, aclk, aresetn, m_valid && !m_column_stop, m_stop_layer == '0, "stop layer set without column stop")

    // A stop with non-zero depth happens at the layer itself
    `ODTA_ASSERT_IMPLIES(a_stop_at_layer, aclk, aresetn, m_valid && m_column_stop && (m_depth_value != '0), m_stop_layer[7:0] == m_layer_index, "stop layer differs from layer index")

endmodule

bind optical_depth_trapezoid_accumulator odta_checker u_odta_checker (.*);

`default_nettype wire
